// ===== hw/rtl/pfl_pkg.sv =====
// Package for the page free list allocator: sizes, codes, FSM states and the
// link memory request bundle. No dependencies.
`default_nettype none

package pfl_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int COUNT_W   = PAGE_W + 1;

    // stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W  = ((PAGE_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((PAGE_W + 2 + 7) / 8) * 8;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_WALK,
        S_LINK_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  wr_en;
        page_t wr_addr;
        page_t wr_data;
        logic  rd_en;
        page_t rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfl_link_mem.sv =====
// Next-free link store: one write port, one read port, registered read data.
// Depends on pfl_pkg.
`default_nettype none

module pfl_link_mem (
    input  wire logic             aclk,
    input  wire pfl_pkg::mem_req_t req,
    output pfl_pkg::page_t         rd_data
);
    import pfl_pkg::*;

    page_t link_mem [MAX_PAGES];
    page_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            link_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= link_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pfl_ctrl.sv =====
// Allocator sequencer: list head, page count, tail walk and result register.
// Depends on pfl_pkg; drives the link memory through a mem_req_t bundle.
`default_nettype none

module pfl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_op,
    input  wire pfl_pkg::page_t    in_page,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pfl_pkg::page_t         out_page,
    output logic [1:0]             out_status,
    output pfl_pkg::mem_req_t      mem_req,
    input  wire pfl_pkg::page_t    mem_rd_data
);
    import pfl_pkg::*;

    state_t  state_reg, state_next;
    page_t   head_reg, head_next;
    count_t  used_reg, used_next;
    page_t   tail_reg, tail_next;
    op_t     op_reg, op_next;
    page_t   page_reg, page_next;
    page_t   res_page_reg, res_page_next;
    status_t res_status_reg, res_status_next;
    logic    out_valid_reg, out_valid_next;
    page_t   out_page_reg, out_page_next;
    status_t out_status_reg, out_status_next;

    logic head_empty, can_grow, free_bad, out_free, walk_end, walk_dup;

    assign head_empty = (head_reg == '0);
    assign can_grow   = (used_reg < COUNT_W'(MAX_PAGES));
    assign free_bad   = (page_reg == '0) || ({1'b0, page_reg} >= used_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign walk_end   = (mem_rd_data == '0);
    assign walk_dup   = (mem_rd_data == page_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (op_reg == OP_ALLOC) begin
                    state_next = head_empty ? S_DONE : S_POP_WAIT;
                end else if (free_bad || head_empty || head_reg == page_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_POP_WAIT: state_next = S_DONE;
            S_WALK: begin
                if (walk_end)      state_next = S_LINK_END;
                else if (walk_dup) state_next = S_DONE;
            end
            S_LINK_END: state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        head_next       = head_reg;
        used_next       = used_reg;
        tail_next       = tail_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        mem_req         = '0;
        in_ready        = 1'b0;

        if (out_valid_reg && out_ready) out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready  = 1'b1;
                op_next   = op_t'(in_op);
                page_next = in_page;
            end
            S_DECODE: begin
                res_page_next   = '0;
                res_status_next = ST_OK;
                if (op_reg == OP_ALLOC) begin
                    if (!head_empty) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_reg;
                    end else if (can_grow) begin
                        // fresh page: its link starts at end of list
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = used_reg[PAGE_W-1:0];
                        mem_req.wr_data = '0;
                        res_page_next   = used_reg[PAGE_W-1:0];
                        used_next       = used_reg + COUNT_W'(1);
                    end else begin
                        res_status_next = ST_FULL;
                    end
                end else if (free_bad || (!head_empty && head_reg == page_reg)) begin
                    res_status_next = ST_REJECT;
                end else if (head_empty) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = page_reg;
                    mem_req.wr_data = '0;
                    head_next       = page_reg;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg;
                    tail_next       = head_reg;
                end
            end
            S_POP_WAIT: begin
                res_page_next = head_reg;
                head_next     = mem_rd_data;
            end
            S_WALK: begin
                if (walk_end) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = tail_reg;
                    mem_req.wr_data = page_reg;
                end else if (walk_dup) begin
                    res_status_next = ST_REJECT;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rd_data;
                    tail_next       = mem_rd_data;
                end
            end
            S_LINK_END: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = page_reg;
                mem_req.wr_data = '0;
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_page_next   = res_page_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            used_reg      <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg       <= tail_next;
        op_reg         <= op_next;
        page_reg       <= page_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_page   = out_page_reg;
    assign out_status = out_status_reg;

    // the link port never reads and writes in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.wr_en && mem_req.rd_en))
        else $error("link memory read and write collide");

    // page count stays within the header page and the store size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != '0) && (used_reg <= COUNT_W'(MAX_PAGES)))
        else $error("page count out of range");

    // the list head is always a page that has been handed out
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_empty || ({1'b0, head_reg} < used_reg))
        else $error("list head beyond page count");

    // a failed allocate or any free reports page zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_page_reg == '0))
        else $error("nonzero page with error status");

    // a new item is taken only after the previous result left the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result not registered on completion");

endmodule

`default_nettype wire

// ===== hw/rtl/page_free_list_allocator.sv =====
// Top level of the page free list allocator: stream ports, sequencer and
// link memory. Depends on pfl_pkg, pfl_ctrl and pfl_link_mem.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tuser: operation; s_tdata: page_number
//  m_       out  m_tvalid/m_tready   m_tdata: granted_page, status
//
// One item at a time. Allocate goes from decode to the result (through a pop
// state when popping the free list, for the link memory read). Free goes to
// the result straight from decode when rejected up front or when the list is
// empty, otherwise it walks the list, one link memory read per step.
// Reset clears head, page count and the result register; the link memory is
// not cleared, every entry on the list is written before it is read.
// A stalled result holds the sequencer in its final state until taken.
`default_nettype none

module page_free_list_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pfl_pkg::S_DATA_W-1:0]  s_tdata,  // [page_number, pad]
    input  wire logic [0:0]                    s_tuser,  // [operation]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pfl_pkg::M_DATA_W-1:0]       m_tdata   // [granted_page, status, pad]
);
    import pfl_pkg::*;

    mem_req_t mem_req;
    page_t    mem_rd_data;
    page_t    out_page;
    logic [1:0] out_status;

    pfl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser[0]),
        .in_page     (s_tdata[PAGE_W-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_page    (out_page),
        .out_status  (out_status),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    pfl_link_mem u_link_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = M_DATA_W'({out_status, out_page});

endmodule

`default_nettype wire

// ===== tb/sv/pfl_grant_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the page free list allocator: tracks the free list and page
// count from accepted requests and compares every result item. Depends on pfl_pkg.

module pfl_grant_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [pfl_pkg::S_DATA_W-1:0] s_tdata,   // [page_number, pad]
    input  wire logic [0:0]                   s_tuser,   // [operation]
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [pfl_pkg::M_DATA_W-1:0] m_tdata,   // [granted_page, status, pad]
    output int                                mismatches,
    output int                                outstanding
);
    import pfl_pkg::*;

    typedef struct packed {
        page_t   page;
        status_t status;
    } grant_t;

    page_t  free_link [MAX_PAGES];
    page_t  free_head;
    count_t used_pages;
    grant_t awaited_grants[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Applies one request to the tracked free list and returns its result.
    task automatic next_grant(input op_t op, input page_t pg, output grant_t g);
        page_t tail;
        bit    walking;
        int    steps;
        g.page   = '0;
        g.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (free_head != '0) begin
                g.page    = free_head;
                free_head = free_link[g.page];
            end else if (used_pages < count_t'(MAX_PAGES)) begin
                g.page            = page_t'(used_pages);
                free_link[g.page] = '0;
                used_pages        = used_pages + 1'b1;
            end else begin
                g.status = ST_FULL;
            end
        end else if (pg == '0 || count_t'(pg) >= used_pages) begin
            g.status = ST_REJECT;
        end else if (free_head == '0) begin
            free_link[pg] = '0;
            free_head     = pg;
        end else begin
            // walk to the tail; a page already on the list is a double free
            tail    = free_head;
            walking = 1'b1;
            steps   = 0;
            while (walking) begin
                if (tail == pg) begin
                    g.status = ST_REJECT;
                    walking  = 1'b0;
                end else if (free_link[tail] == '0 || steps + 1 >= MAX_PAGES) begin
                    walking = 1'b0;
                end else begin
                    steps++;
                    tail = free_link[tail];
                end
            end
            if (g.status == ST_OK) begin
                free_link[pg]   = '0;
                free_link[tail] = pg;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        grant_t want;
        grant_t got;
        if (!aresetn) begin
            free_head  = '0;
            used_pages = count_t'(1);
            awaited_grants.delete();
        end else begin
            // results first: an item accepted at this edge cannot finish at it
            if (m_tvalid && m_tready) begin
                got.page   = m_tdata[PAGE_W-1:0];
                got.status = status_t'(m_tdata[PAGE_W+1:PAGE_W]);
                if (awaited_grants.size() == 0) begin
                    $display("%0t: unexpected result item, page %0d status %0d",
                             $time, got.page, got.status);
                    mismatches++;
                end else begin
                    want = awaited_grants.pop_front();
                    if (got.page != want.page) begin
                        $display("%0t: granted_page expected %0d actual %0d",
                                 $time, want.page, got.page);
                        mismatches++;
                    end
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                next_grant(op_t'(s_tuser[0]), s_tdata[PAGE_W-1:0], want);
                awaited_grants.push_back(want);
            end
        end
        outstanding = awaited_grants.size();
    end

endmodule

// ===== tb/sv/tb_page_free_list_allocator.sv =====
`timescale 1ns / 100ps
// Testbench top for the page free list allocator: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on pfl_pkg and pfl_grant_checker.

module tb_page_free_list_allocator;
    import pfl_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    wire                 s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [page_number, pad]
    logic [0:0]          s_tuser;   // [operation]
    wire                 m_tvalid;
    logic                m_tready;
    wire  [M_DATA_W-1:0] m_tdata;   // [granted_page, status, pad]

    int    mismatches;
    int    outstanding;
    page_t held_pages[$];
    page_t returned_pages[$];
    bit    saw_full;
    int    results_seen;
    int    idle_cycles;
    bit    tx_calm;
    int    items_sent;

    page_free_list_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pfl_grant_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Track granted pages for free requests; also the stall watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            case (m_tdata[PAGE_W+1:PAGE_W])
                ST_OK:   if (m_tdata[PAGE_W-1:0] != '0)
                             held_pages.push_back(m_tdata[PAGE_W-1:0]);
                ST_FULL: saw_full = 1'b1;
                default: ;
            endcase
        end
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            idle_cycles = 0;
        end else if (aresetn) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("page_free_list_allocator: mismatch");
                $finish;
            end
        end
    end

    // Result side back-pressure: random stalls, calm stretches, one long hold.
    initial begin : result_sink
        int  stall_left;
        int  cycle_no;
        bit  rx_calm;
        bit  hold_done;
        stall_left = 0;
        cycle_no   = 0;
        rx_calm    = 1'b0;
        hold_done  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle_no++;
            if (cycle_no % 256 == 0)
                rx_calm = $urandom_range(1);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 150) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (!rx_calm && $urandom_range(99) < 25) begin
                stall_left = gap_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one item and returns right after the edge that accepts it.
    task automatic send_item(input op_t op, input page_t pg);
        int gap;
        gap = 0;
        items_sent++;
        if (items_sent % 64 == 0)
            tx_calm = $urandom_range(1);
        if (!tx_calm && $urandom_range(99) < 25)
            gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W-PAGE_W){1'b0}}, pg};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Allocates at the given percentage; otherwise frees of pages we hold (well formed), double frees and noise.
    task automatic random_item(input int alloc_pct);
        int    pick;
        int    idx;
        page_t pg;
        pick = $urandom_range(99);
        pg   = page_t'($urandom_range(MAX_PAGES-1));
        if (pick < alloc_pct) begin
            send_item(OP_ALLOC, pg);
        end else if (pick < 75 && held_pages.size() > 0) begin
            idx = $urandom_range(held_pages.size() - 1);
            pg  = held_pages[idx];
            held_pages.delete(idx);
            returned_pages.push_back(pg);
            if (returned_pages.size() > 32)
                returned_pages.delete(0);
            send_item(OP_FREE, pg);
        end else if (pick < 82 && returned_pages.size() > 0) begin
            send_item(OP_FREE, returned_pages[$urandom_range(returned_pages.size() - 1)]);
        end else if (pick < 90) begin
            send_item(OP_FREE, pg);
        end else if (pick < 95) begin
            send_item(OP_FREE, '0);
        end else begin
            send_item(OP_FREE, page_t'($urandom_range(15)));
        end
    endtask

    // Stop offering and wait until every result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        saw_full     = 1'b0;
        results_seen = 0;
        idle_cycles  = 0;
        tx_calm      = 1'b0;
        items_sent   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_ALLOC;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fresh pages, header and range rejects, empty-list free, tail walks,
        // double frees, pops in list order
        send_item(OP_ALLOC, page_t'(MAX_PAGES-1));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, page_t'('h2AA));
        send_item(OP_FREE, '0);
        send_item(OP_FREE, page_t'(MAX_PAGES-1));
        send_item(OP_FREE, page_t'(4));
        send_item(OP_FREE, page_t'(2));
        send_item(OP_FREE, page_t'(2));
        send_item(OP_FREE, page_t'(3));
        send_item(OP_FREE, page_t'(1));
        send_item(OP_FREE, page_t'(3));
        send_item(OP_FREE, page_t'(1));
        send_item(OP_ALLOC, page_t'('h155));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, page_t'(MAX_PAGES-1));
        send_item(OP_FREE, page_t'('h155));

        repeat (RANDOM_ITEMS) random_item(45);

        // run the store up to full
        while (!saw_full) send_item(OP_ALLOC, page_t'($urandom_range(MAX_PAGES-1)));
        settle();

        // full store: top page freed, double freed, re-granted, then store full
        send_item(OP_FREE, page_t'(MAX_PAGES-1));
        send_item(OP_FREE, page_t'(MAX_PAGES-1));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, page_t'(MAX_PAGES-1));
        send_item(OP_FREE, '0);
        send_item(OP_ALLOC, page_t'('h3C3));

        // long free list, then drain it again
        repeat (150) random_item(10);
        repeat (100) random_item(60);
        settle();

        if (mismatches == 0)
            $display("page_free_list_allocator: match");
        else
            $display("page_free_list_allocator: mismatch");
        $finish;
    end

endmodule
